@@ src/rvsu_pkg.sv @@
// Shared constants, register codes and types of the raw video scanline unpacker.
`default_nettype none
package rvsu_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int COLOR_W     = 24;
    localparam int ROW_W       = 13;
    localparam int PIX_W       = $clog2(MAX_WIDTH + 1);
    localparam int STRIDE_W    = $clog2(4 * MAX_WIDTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 32;

    localparam logic [3:0] MODE_1BPP   = 4'd0;
    localparam logic [3:0] MODE_2BPP   = 4'd1;
    localparam logic [3:0] MODE_4BPP   = 4'd2;
    localparam logic [3:0] MODE_8BPP   = 4'd3;
    localparam logic [3:0] MODE_RGB555 = 4'd4;
    localparam logic [3:0] MODE_RGB24  = 4'd5;
    localparam logic [3:0] MODE_ARGB32 = 4'd6;
    localparam logic [3:0] MODE_GRAY2  = 4'd7;
    localparam logic [3:0] MODE_GRAY4  = 4'd8;
    localparam logic [3:0] MODE_GRAY8  = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 2'd1;

    typedef struct packed {
        logic               we;
        logic [PAL_AW-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } pal_wr_t;

endpackage
`default_nettype wire

@@ src/rvsu_palette_ram.sv @@
// Palette memory: one write port, one registered read port.
`default_nettype none
module rvsu_palette_ram (
    input  wire logic                         aclk,
    input  wire rvsu_pkg::pal_wr_t            wr,
    input  wire logic                         rd_en,
    input  wire logic [rvsu_pkg::PAL_AW-1:0]  rd_addr,
    output logic      [rvsu_pkg::COLOR_W-1:0] rd_data
);

    logic [rvsu_pkg::COLOR_W-1:0] mem [rvsu_pkg::PAL_ENTRIES];
    logic [rvsu_pkg::COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ src/raw_video_scanline_unpacker.sv @@
// Top level of the raw video scanline unpacker: byte expander, palette lookup, output register.
// The block emits at most one pixel per cycle, none while the output stalls. A frame byte that
// yields several pixels holds the expander until its last pixel is stepped out; bytes that only
// gather, pad bytes and palette writes finish in the expander step that takes them. Pixels pass
// the pixel stage with the palette read, then the output register. A new word is accepted in
// the cycle the expander finishes the previous one. Mode and width writes restart the row.
`default_nettype none
module raw_video_scanline_unpacker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // data_byte, pal_index, pal_red, pal_green, pal_blue
    input  wire logic [rvsu_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // red, green, blue, alpha
    output logic      [rvsu_pkg::OUT_DATA_W-1:0]  m_tdata,
    // row_end
    output logic                                  m_tuser,
    // last
    output logic                                  m_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rvsu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rvsu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PW = rvsu_pkg::PIX_W;
    localparam int SW = rvsu_pkg::STRIDE_W;
    localparam int CW = rvsu_pkg::COLOR_W;

    // configuration
    logic [3:0]    depth_reg;
    logic [PW-1:0] eff_w_reg;
    logic [PW-1:0] eff_w_next;
    logic          cfg_write;

    // expander
    logic                        exp_valid_reg;
    logic                        exp_pal_reg;
    logic [7:0]                  exp_byte_reg;
    logic [rvsu_pkg::PAL_AW-1:0] exp_idx_reg;
    logic [CW-1:0]               exp_color_reg;
    logic [2:0]                  k_reg;
    logic [2:0]                  k_next;

    // row state
    logic [PW-1:0] pix_reg;
    logic [PW-1:0] pix_next;
    logic [SW-1:0] bcnt_reg;
    logic [SW-1:0] bcnt_next;
    logic [CW-1:0] gather_reg;
    logic [CW-1:0] gather_next;
    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;

    // pixel stage
    logic          p1_valid_reg;
    logic          p1_lookup_reg;
    logic [CW-1:0] p1_rgb_reg;
    logic [7:0]    p1_alpha_reg;
    logic          p1_row_end_reg;
    logic          p1_last_reg;

    // output register
    logic                              m_valid_reg;
    logic [rvsu_pkg::OUT_DATA_W-1:0]   m_data_reg;
    logic                              m_row_end_reg;
    logic                              m_last_reg;

    logic                        in_accept;
    logic                        out_load;
    logic                        p1_free;
    logic                        step;
    logic                        done;
    logic                        emit;
    logic                        lookup;
    logic [CW-1:0]               rgb_px;
    logic [7:0]                  alpha_px;
    logic                        last_px;
    logic                        row_end_px;
    logic                        indexed;
    logic [1:0]                  lg;
    logic [1:0]                  final_phase;
    logic [2:0]                  last_k;
    logic [7:0]                  sh;
    logic [rvsu_pkg::PAL_AW-1:0] rd_addr;
    logic [CW-1:0]               rd_data;
    logic [SW-1:0]               w_ext;
    logic [SW-1:0]               stride_raw;
    logic [SW-1:0]               stride;
    logic [SW-1:0]               bcnt_inc;
    logic [15:0]                 px555;
    rvsu_pkg::pal_wr_t           pal_wr;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        if (cfg_data == '0) begin
            eff_w_next = PW'(1);
        end else if (32'(cfg_data) > 32'(rvsu_pkg::MAX_WIDTH)) begin
            eff_w_next = PW'(rvsu_pkg::MAX_WIDTH);
        end else begin
            eff_w_next = PW'(cfg_data);
        end
    end

    // mode decode
    always_comb begin
        indexed     = 1'b1;
        lg          = 2'd3;
        final_phase = 2'd3;
        unique case (depth_reg)
            rvsu_pkg::MODE_1BPP:   lg = 2'd0;
            rvsu_pkg::MODE_2BPP,
            rvsu_pkg::MODE_GRAY2:  lg = 2'd1;
            rvsu_pkg::MODE_4BPP,
            rvsu_pkg::MODE_GRAY4:  lg = 2'd2;
            rvsu_pkg::MODE_8BPP,
            rvsu_pkg::MODE_GRAY8:  lg = 2'd3;
            rvsu_pkg::MODE_RGB555: begin
                indexed     = 1'b0;
                final_phase = 2'd1;
            end
            rvsu_pkg::MODE_RGB24: begin
                indexed     = 1'b0;
                final_phase = 2'd2;
            end
            default: begin
                indexed     = 1'b0;
                final_phase = 2'd3;
            end
        endcase
    end

    // row stride in bytes, padded to even
    assign w_ext = SW'(eff_w_reg);
    always_comb begin
        unique case (depth_reg)
            rvsu_pkg::MODE_1BPP:   stride_raw = (w_ext + SW'(7)) >> 3;
            rvsu_pkg::MODE_2BPP,
            rvsu_pkg::MODE_GRAY2:  stride_raw = (w_ext + SW'(3)) >> 2;
            rvsu_pkg::MODE_4BPP,
            rvsu_pkg::MODE_GRAY4:  stride_raw = (w_ext + SW'(1)) >> 1;
            rvsu_pkg::MODE_RGB555: stride_raw = w_ext << 1;
            rvsu_pkg::MODE_RGB24:  stride_raw = (w_ext << 1) + w_ext;
            rvsu_pkg::MODE_ARGB32: stride_raw = w_ext << 2;
            default:               stride_raw = w_ext;
        endcase
    end
    assign stride   = stride_raw + SW'(stride_raw[0]);
    assign bcnt_inc = bcnt_reg + SW'(1);

    assign last_k     = 3'(3'd7 >> lg);
    assign sh         = exp_byte_reg << 3'(k_reg << lg);
    assign row_end_px = (pix_reg + PW'(1)) == eff_w_reg;
    assign px555      = {gather_reg[7:0], exp_byte_reg};

    always_comb begin
        unique case (lg)
            2'd0:    rd_addr = {7'd0, sh[7]};
            2'd1:    rd_addr = {6'd0, sh[7:6]};
            2'd2:    rd_addr = {4'd0, sh[7:4]};
            default: rd_addr = sh;
        endcase
    end

    assign out_load = p1_valid_reg && (!m_valid_reg || m_tready);
    assign p1_free  = !p1_valid_reg || out_load;
    assign step     = exp_valid_reg && p1_free;
    assign s_tready = !exp_valid_reg || (step && done);

    always_comb begin
        pix_next    = pix_reg;
        bcnt_next   = bcnt_reg;
        gather_next = gather_reg;
        phase_next  = phase_reg;
        k_next      = k_reg;
        done        = 1'b0;
        emit        = 1'b0;
        lookup      = 1'b0;
        rgb_px      = '0;
        alpha_px    = 8'hFF;
        last_px     = 1'b0;
        pal_wr.we   = 1'b0;
        pal_wr.addr = exp_idx_reg;
        pal_wr.data = exp_color_reg;
        if (step) begin
            if (exp_pal_reg) begin
                pal_wr.we = 1'b1;
                done      = 1'b1;
            end else if (depth_reg > rvsu_pkg::MODE_GRAY8) begin
                done = 1'b1;
            end else begin
                if (pix_reg < eff_w_reg) begin
                    if (indexed) begin
                        emit     = 1'b1;
                        lookup   = 1'b1;
                        pix_next = pix_reg + PW'(1);
                        last_px  = (k_reg == last_k) || row_end_px;
                        done     = last_px;
                        k_next   = last_px ? 3'd0 : k_reg + 3'd1;
                    end else if (phase_reg >= final_phase) begin
                        emit     = 1'b1;
                        last_px  = 1'b1;
                        done     = 1'b1;
                        pix_next = pix_reg + PW'(1);
                        gather_next = '0;
                        phase_next  = 2'd0;
                        if (depth_reg == rvsu_pkg::MODE_RGB555) begin
                            rgb_px = {px555[14:10], 3'd0, px555[9:5], 3'd0,
                                      px555[4:0], 3'd0};
                        end else if (depth_reg == rvsu_pkg::MODE_RGB24) begin
                            rgb_px = {gather_reg[15:0], exp_byte_reg};
                        end else begin
                            rgb_px   = {gather_reg[15:0], exp_byte_reg};
                            alpha_px = gather_reg[23:16];
                        end
                    end else begin
                        gather_next = {gather_reg[15:0], exp_byte_reg};
                        phase_next  = phase_reg + 2'd1;
                        done        = 1'b1;
                    end
                end else begin
                    done = 1'b1;
                end
                if (done) begin
                    bcnt_next = bcnt_inc;
                    if (bcnt_inc >= stride) begin
                        pix_next    = '0;
                        bcnt_next   = '0;
                        gather_next = '0;
                        phase_next  = 2'd0;
                    end
                end
            end
        end
        if (cfg_write && (cfg_index == rvsu_pkg::REG_DEPTH_MODE ||
                          cfg_index == rvsu_pkg::REG_ROW_WIDTH)) begin
            pix_next    = '0;
            bcnt_next   = '0;
            gather_next = '0;
            phase_next  = 2'd0;
        end
    end

    rvsu_palette_ram u_palette (
        .aclk    (aclk),
        .wr      (pal_wr),
        .rd_en   (p1_free),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= rvsu_pkg::MODE_ARGB32;
            eff_w_reg     <= PW'(1);
            exp_valid_reg <= 1'b0;
            k_reg         <= 3'd0;
            pix_reg       <= '0;
            bcnt_reg      <= '0;
            gather_reg    <= '0;
            phase_reg     <= 2'd0;
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (in_accept) begin
                exp_valid_reg <= 1'b1;
            end else if (step && done) begin
                exp_valid_reg <= 1'b0;
            end
            k_reg      <= k_next;
            pix_reg    <= pix_next;
            bcnt_reg   <= bcnt_next;
            gather_reg <= gather_next;
            phase_reg  <= phase_next;
            if (cfg_write) begin
                if (cfg_index == rvsu_pkg::REG_DEPTH_MODE) begin
                    depth_reg <= cfg_data[3:0];
                end else if (cfg_index == rvsu_pkg::REG_ROW_WIDTH) begin
                    eff_w_reg <= eff_w_next;
                end
            end
            if (p1_free) begin
                p1_valid_reg <= emit;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            exp_pal_reg   <= s_tuser;
            exp_byte_reg  <= s_tdata[7:0];
            exp_idx_reg   <= s_tdata[15:8];
            exp_color_reg <= {s_tdata[31:24], s_tdata[47:40], s_tdata[63:56]};
        end
        if (p1_free) begin
            p1_lookup_reg  <= lookup;
            p1_rgb_reg     <= rgb_px;
            p1_alpha_reg   <= alpha_px;
            p1_row_end_reg <= row_end_px;
            p1_last_reg    <= last_px;
        end
        if (out_load) begin
            m_data_reg <= p1_lookup_reg
                ? {p1_alpha_reg, rd_data[7:0], rd_data[15:8], rd_data[23:16]}
                : {p1_alpha_reg, p1_rgb_reg[7:0], p1_rgb_reg[15:8], p1_rgb_reg[23:16]};
            m_row_end_reg <= p1_row_end_reg;
            m_last_reg    <= p1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_row_end_reg;
    assign m_tlast  = m_last_reg;

    a_pix_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_reg <= eff_w_reg)
        else $error("pixel count beyond row width");

    a_byte_in_stride: assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg < stride)
        else $error("byte count reached row stride");

    a_k_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !exp_valid_reg |-> k_reg == 3'd0)
        else $error("sub-byte index left over after byte finished");

    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !out_load) |=> (p1_valid_reg && $stable(p1_rgb_reg)
                                         && $stable(rd_data)))
        else $error("stalled pixel stage lost its contents");

endmodule
`default_nettype wire

@@ dv/raw_video_scanline_unpacker_tb.sv @@
// Self-checking testbench for the raw video scanline unpacker: a directed table, then random frames.
module raw_video_scanline_unpacker_tb;

    localparam logic [rvsu_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [3:0] MODE_BAD_LO = 4'd10;
    localparam logic [3:0] MODE_BAD_HI = 4'd15;
    localparam logic REQ_FRAME   = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS  = 220;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       last;
    } pixel_t;

    typedef enum logic [1:0] {STEP_CFG, STEP_PAL, STEP_BYTE} step_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

    typedef struct {
        step_t                           kind;
        logic [rvsu_pkg::CFG_IDX_W-1:0]  idx;
        logic [rvsu_pkg::CFG_DATA_W-1:0] val;
        logic [63:0]                     word;
        chk_t                            chk;
        pixel_t                          pix;
    } plan_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rvsu_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rvsu_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [rvsu_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rvsu_pkg::CFG_DATA_W-1:0] cfg_data;

    raw_video_scanline_unpacker dut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    logic [23:0] pal_mem [rvsu_pkg::PAL_ENTRIES];
    bit          pal_known [rvsu_pkg::PAL_ENTRIES];
    logic [7:0]  known_idx [$];
    logic [23:0] gather;
    logic [1:0]  phase;
    logic [12:0] pix_cnt;
    logic [14:0] byte_cnt;
    logic [3:0]  mode_r;
    logic [12:0] width_r;

    pixel_t    fresh_pixels [$];
    pixel_t    expected_pixels [$];
    plan_row_t plan [$];

    int send_idle = 24;
    int recv_idle = 53;
    int mismatch_count = 0;
    int pixels_seen = 0;
    int words_sent = 0;
    int settings_used = 0;

    function automatic pixel_t px_of(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] a,
                                     input logic re, input logic l);
        pixel_t p;
        p.red = r;
        p.green = g;
        p.blue = b;
        p.alpha = a;
        p.row_end = re;
        p.last = l;
        return p;
    endfunction

    function automatic int unsigned active_width();
        if (width_r == '0) return 1;
        if (32'(width_r) > rvsu_pkg::MAX_WIDTH) return rvsu_pkg::MAX_WIDTH;
        return 32'(width_r);
    endfunction

    function automatic int unsigned mode_depth(input logic [3:0] m);
        case (m)
            rvsu_pkg::MODE_1BPP:                        return 1;
            rvsu_pkg::MODE_2BPP, rvsu_pkg::MODE_GRAY2:  return 2;
            rvsu_pkg::MODE_4BPP, rvsu_pkg::MODE_GRAY4:  return 4;
            rvsu_pkg::MODE_8BPP, rvsu_pkg::MODE_GRAY8:  return 8;
            rvsu_pkg::MODE_RGB555:                      return 16;
            rvsu_pkg::MODE_RGB24:                       return 24;
            default:                                    return 32;
        endcase
    endfunction

    function automatic void restart_row();
        gather = '0;
        phase = '0;
        pix_cnt = '0;
        byte_cnt = '0;
    endfunction

    function automatic void emit(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input logic [7:0] a,
                                 input int unsigned w);
        pix_cnt++;
        fresh_pixels.push_back(px_of(r, g, b, a, pix_cnt == w, 1'b0));
    endfunction

    function automatic void apply_reg(input logic [rvsu_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [rvsu_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            rvsu_pkg::REG_DEPTH_MODE: begin
                mode_r = val[3:0];
                restart_row();
            end
            rvsu_pkg::REG_ROW_WIDTH: begin
                width_r = val;
                restart_row();
            end
            default: ;
        endcase
    endfunction

    function automatic void unpack_word(input logic req, input logic [63:0] word);
        int unsigned w, bpp, stride, per, k;
        logic [7:0]  b, idx;
        logic [15:0] px;
        logic [23:0] c;
        pixel_t      tail;
        fresh_pixels.delete();
        if (req == REQ_PALETTE) begin
            pal_mem[word[15:8]] = {word[31:24], word[47:40], word[63:56]};
            if (!pal_known[word[15:8]]) begin
                pal_known[word[15:8]] = 1'b1;
                known_idx.push_back(word[15:8]);
            end
            return;
        end
        if (mode_r > rvsu_pkg::MODE_GRAY8) return;
        w = active_width();
        bpp = mode_depth(mode_r);
        stride = (w * bpp + 7) / 8;
        if (stride % 2) stride++;
        b = word[7:0];
        if (pix_cnt < w) begin
            if (bpp <= 8) begin
                per = 8 / bpp;
                for (k = 0; k < per && pix_cnt < w; k++) begin
                    idx = 8'((b >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1));
                    c = pal_mem[idx];
                    emit(c[23:16], c[15:8], c[7:0], 8'hFF, w);
                end
            end else if (phase + 1 >= bpp / 8) begin
                case (mode_r)
                    rvsu_pkg::MODE_RGB555: begin
                        px = {gather[7:0], b};
                        emit({px[14:10], 3'b0}, {px[9:5], 3'b0}, {px[4:0], 3'b0}, 8'hFF, w);
                    end
                    rvsu_pkg::MODE_RGB24: emit(gather[15:8], gather[7:0], b, 8'hFF, w);
                    default: emit(gather[15:8], gather[7:0], b, gather[23:16], w);
                endcase
                gather = '0;
                phase = '0;
            end else begin
                gather = {gather[15:0], b};
                phase++;
            end
        end
        byte_cnt++;
        if (byte_cnt >= stride) restart_row();
        if (fresh_pixels.size() != 0) begin
            tail = fresh_pixels.pop_back();
            tail.last = 1'b1;
            fresh_pixels.push_back(tail);
        end
    endfunction

    function automatic logic [63:0] pal_word(input logic [7:0] idx);
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        w[15:8] = idx;
        return w;
    endfunction

    function automatic logic [7:0] pick_frame_byte();
        if ((mode_r == rvsu_pkg::MODE_8BPP || mode_r == rvsu_pkg::MODE_GRAY8) &&
            pix_cnt < active_width())
            return known_idx[$urandom_range(known_idx.size() - 1)];
        return 8'($urandom_range(255));
    endfunction

    function automatic void add_reg(input logic [rvsu_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [rvsu_pkg::CFG_DATA_W-1:0] val);
        plan_row_t r;
        r.kind = STEP_CFG;
        r.idx = idx;
        r.val = val;
        r.word = '0;
        r.chk = CHK_NONE;
        r.pix = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_pal(input logic [7:0] idx, input logic [15:0] red,
                                    input logic [15:0] green, input logic [15:0] blue);
        plan_row_t r;
        r.kind = STEP_PAL;
        r.idx = '0;
        r.val = '0;
        r.word = {blue, green, red, idx, 8'($urandom_range(255))};
        r.chk = CHK_NONE;
        r.pix = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input chk_t chk, input pixel_t pix);
        plan_row_t r;
        r.kind = STEP_BYTE;
        r.idx = '0;
        r.val = '0;
        r.word = {$urandom(), $urandom()};
        r.word[7:0] = b;
        r.chk = chk;
        r.pix = pix;
        plan.push_back(r);
    endfunction

    task automatic drive_word(input logic req, input logic [63:0] word);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= word;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_checked(input logic req, input logic [63:0] word);
        unpack_word(req, word);
        foreach (fresh_pixels[j]) expected_pixels.push_back(fresh_pixels[j]);
        drive_word(req, word);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rvsu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rvsu_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin : watch_pixels
        pixel_t got, want;
        m_tready <= ($urandom_range(99) >= recv_idle);
        if (aresetn && m_tvalid && m_tready) begin
            got = px_of(m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
                        m_tuser, m_tlast);
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected pixel r=%02h g=%02h b=%02h a=%02h row_end=%0b last=%0b",
                             got.red, got.green, got.blue, got.alpha, got.row_end, got.last);
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"pixel %0d: expected r=%02h g=%02h b=%02h a=%02h ",
                                  "row_end=%0b last=%0b, got r=%02h g=%02h b=%02h a=%02h ",
                                  "row_end=%0b last=%0b"},
                                 pixels_seen, want.red, want.green, want.blue, want.alpha,
                                 want.row_end, want.last, got.red, got.green, got.blue,
                                 got.alpha, got.row_end, got.last);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int          words, n, r;
        logic [3:0]  pick;
        logic [12:0] wid;
        logic [63:0] word;
        logic        req;

        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        mode_r = rvsu_pkg::MODE_ARGB32;
        width_r = 13'd1;
        restart_row();

        add_byte(8'hFF, CHK_NONE, '0);
        add_byte(8'h00, CHK_NONE, '0);
        add_byte(8'h80, CHK_NONE, '0);
        add_byte(8'h7F, CHK_ONE, px_of(8'h00, 8'h80, 8'h7F, 8'hFF, 1'b1, 1'b1));
        add_pal(8'd0, 16'hFFFF, 16'h0000, 16'h8000);
        add_pal(8'd1, 16'h00FF, 16'hFF00, 16'hFFFF);
        add_pal(8'd255, 16'h1234, 16'h5678, 16'h9ABC);
        add_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_1BPP));
        add_reg(rvsu_pkg::REG_ROW_WIDTH, 13'd0);
        add_byte(8'h80, CHK_ONE, px_of(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        add_byte(8'h5A, CHK_NONE, '0);
        add_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(MODE_BAD_LO));
        add_byte(8'hC3, CHK_NONE, '0);
        add_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(MODE_BAD_HI));
        add_reg(rvsu_pkg::REG_ROW_WIDTH, 13'd8191);
        add_byte(8'h00, CHK_NONE, '0);
        add_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_1BPP));
        add_byte(8'hA5, CHK_MODEL, '0);
        add_reg(REG_SPARE, 13'd5);
        add_byte(8'h3C, CHK_MODEL, '0);
        add_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_8BPP));
        add_reg(rvsu_pkg::REG_ROW_WIDTH, 13'd3);
        add_byte(8'hFF, CHK_ONE, px_of(8'h12, 8'h56, 8'h9A, 8'hFF, 1'b0, 1'b1));
        add_byte(8'h00, CHK_ONE, px_of(8'hFF, 8'h00, 8'h80, 8'hFF, 1'b0, 1'b1));
        add_byte(8'h01, CHK_ONE, px_of(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        add_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_RGB555));
        add_reg(rvsu_pkg::REG_ROW_WIDTH, 13'd1);
        add_byte(8'hFF, CHK_NONE, '0);
        add_byte(8'hFF, CHK_ONE, px_of(8'hF8, 8'hF8, 8'hF8, 8'hFF, 1'b1, 1'b1));
        add_byte(8'h7C, CHK_NONE, '0);
        add_byte(8'h00, CHK_ONE, px_of(8'hF8, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1));
        add_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_RGB24));
        add_byte(8'h01, CHK_NONE, '0);
        add_byte(8'h02, CHK_NONE, '0);
        add_byte(8'h03, CHK_ONE, px_of(8'h01, 8'h02, 8'h03, 8'hFF, 1'b1, 1'b1));
        add_byte(8'h44, CHK_NONE, '0);
        add_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_2BPP));
        add_reg(rvsu_pkg::REG_ROW_WIDTH, 13'd3);
        add_byte(8'h44, CHK_MODEL, '0);
        add_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_GRAY2));
        add_reg(rvsu_pkg::REG_ROW_WIDTH, 13'd2);
        add_byte(8'h10, CHK_MODEL, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                STEP_CFG: begin
                    go_idle();
                    write_reg(plan[i].idx, plan[i].val);
                end
                default: begin
                    req = (plan[i].kind == STEP_PAL) ? REQ_PALETTE : REQ_FRAME;
                    unpack_word(req, plan[i].word);
                    if (plan[i].chk == CHK_MODEL)
                        foreach (fresh_pixels[j]) expected_pixels.push_back(fresh_pixels[j]);
                    else if (plan[i].chk == CHK_ONE)
                        expected_pixels.push_back(plan[i].pix);
                    drive_word(req, plan[i].word);
                end
            endcase
        end

        // sub-byte modes index entries 0 to 15 only
        for (int e = 0; e < 16; e++) send_checked(REQ_PALETTE, pal_word(8'(e)));
        words = 16;

        while (words < RANDOM_WORDS) begin
            if (words < RANDOM_WORDS / 3) begin
                send_idle = 24;
                recv_idle <= 53;
            end else if (words < 2 * RANDOM_WORDS / 3) begin
                send_idle = 53;
                recv_idle <= 24;
            end else begin
                send_idle = 0;
                recv_idle <= 0;
            end
            go_idle();
            case (settings_used)
                0: begin
                    write_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_1BPP));
                    write_reg(rvsu_pkg::REG_ROW_WIDTH, 13'd1);
                end
                1: begin
                    write_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_GRAY8));
                    write_reg(rvsu_pkg::REG_ROW_WIDTH, 13'd4096);
                end
                2: begin
                    write_reg(rvsu_pkg::REG_DEPTH_MODE, 13'(rvsu_pkg::MODE_ARGB32));
                    write_reg(rvsu_pkg::REG_ROW_WIDTH, 13'd8191);
                end
                default: begin
                    pick = 4'($urandom_range(9));
                    if ($urandom_range(11) == 0) pick = 4'($urandom_range(15, 10));
                    r = $urandom_range(99);
                    if (r < 70) wid = 13'($urandom_range(12, 1));
                    else if (r < 90) wid = 13'($urandom_range(64, 13));
                    else begin
                        case ($urandom_range(3))
                            0: wid = 13'd0;
                            1: wid = 13'd4096;
                            2: wid = 13'd8191;
                            default: wid = 13'($urandom_range(8191, 4097));
                        endcase
                    end
                    case ($urandom_range(3))
                        0: write_reg(rvsu_pkg::REG_DEPTH_MODE,
                                     {9'($urandom_range(511)), pick});
                        1: write_reg(rvsu_pkg::REG_ROW_WIDTH, wid);
                        2: begin
                            write_reg(REG_SPARE, 13'($urandom_range(8191)));
                            write_reg(rvsu_pkg::REG_DEPTH_MODE,
                                      {9'($urandom_range(511)), pick});
                        end
                        default: begin
                            write_reg(rvsu_pkg::REG_DEPTH_MODE,
                                      {9'($urandom_range(511)), pick});
                            write_reg(rvsu_pkg::REG_ROW_WIDTH, wid);
                        end
                    endcase
                end
            endcase
            settings_used++;
            n = $urandom_range(28, 6);
            repeat (n) begin
                if ($urandom_range(99) < 15) begin
                    send_checked(REQ_PALETTE, pal_word(8'($urandom_range(255))));
                    words++;
                end else begin
                    word = {$urandom(), $urandom()};
                    word[7:0] = pick_frame_byte();
                    send_checked(REQ_FRAME, word);
                    if (mode_r <= rvsu_pkg::MODE_GRAY8) words++;
                end
            end
        end

        go_idle();
        $display("Run drove %0d words: directed rows, then %0d random register settings.",
                 words_sent, settings_used);
        $display("%0d pixels compared, %0d mismatches, %0d still expected.",
                 pixels_seen, mismatch_count, expected_pixels.size());
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ raw_video_scanline_unpacker.f @@
src/rvsu_pkg.sv
src/rvsu_palette_ram.sv
src/raw_video_scanline_unpacker.sv
dv/raw_video_scanline_unpacker_tb.sv
